[hdl/assert_macros.svh]
// Assertion macros used by the compression core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence in the following cycle
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
// Check that a condition always holds
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`endif

[hdl/aesmmo_pkg.sv]
// Types, constants and AES functions for the MMO compression core
package aesmmo_pkg;

  localparam int unsigned NumRounds = 10;

  typedef struct packed {
    logic [63:0] key_hi;
    logic [63:0] key_lo;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] out_hi;
    logic [63:0] out_lo;
  } out_item_t;

  typedef struct packed {
    logic         vld;
    logic [3:0]   rnd;
    logic [127:0] blk;
    logic [127:0] st;
    logic [127:0] rk;
    logic [7:0]   rcon;
  } cell_data_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] s [256];
    s = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = s[x];
  endfunction

endpackage

[hdl/aesmmo_cell.sv]
// One AES round plus one key schedule step, registered
module aesmmo_cell
  import aesmmo_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_data_t din,
  output cell_data_t dout
);

  logic [7:0]   sb  [16];
  logic [7:0]   mc  [16];
  logic [127:0] nrk;
  logic [31:0]  w0, w1, w2, w3, tw;
  logic [127:0] nst;
  logic         last;

  assign last = (din.rnd == 4'(NumRounds));

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4*c] = sbox(din.st[8*(r + 4*((c + r) & 3)) +: 8]);
      end
      mc[4*c]   = xtime(sb[4*c]) ^ xtime(sb[4*c+1]) ^ sb[4*c+1] ^ sb[4*c+2] ^ sb[4*c+3];
      mc[4*c+1] = sb[4*c] ^ xtime(sb[4*c+1]) ^ xtime(sb[4*c+2]) ^ sb[4*c+2] ^ sb[4*c+3];
      mc[4*c+2] = sb[4*c] ^ sb[4*c+1] ^ xtime(sb[4*c+2]) ^ xtime(sb[4*c+3]) ^ sb[4*c+3];
      mc[4*c+3] = xtime(sb[4*c]) ^ sb[4*c] ^ sb[4*c+1] ^ sb[4*c+2] ^ xtime(sb[4*c+3]);
    end
    tw = {sbox(din.rk[103:96]), sbox(din.rk[127:120]), sbox(din.rk[119:112]),
          sbox(din.rk[111:104]) ^ din.rcon};
    w0 = din.rk[31:0] ^ tw;
    w1 = din.rk[63:32] ^ w0;
    w2 = din.rk[95:64] ^ w1;
    w3 = din.rk[127:96] ^ w2;
    nrk = {w3, w2, w1, w0};
    for (int i = 0; i < 16; i++) begin
      nst[8*i +: 8] = (last ? sb[i] : mc[i]) ^ nrk[8*i +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.rnd  <= din.rnd + 4'd1;
    dout.blk  <= din.blk;
    dout.st   <= nst;
    dout.rk   <= nrk;
    dout.rcon <= xtime(din.rcon);
  end

endmodule

[hdl/aes128_mmo_compress_core.sv]
// Top level: AES-128 Matyas-Meyer-Oseas compression as a chain of round cells
//
// channel | signals            | handshake
// input   | start, busy, din   | taken when start && !busy
// result  | done, dout         | one cycle, done strobe, no stall
//
// One item per cycle; each item's result passes through the whitening register,
// loaded at the edge that takes it, and then through the ten round cells before
// it is on dout.
// busy is always low; the chain never stalls. Reset clears the valid chain.
`include "assert_macros.svh"
module aes128_mmo_compress_core
  import aesmmo_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  din,
  output logic      done,
  output out_item_t dout
);

  cell_data_t stage [NumRounds + 1];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage[0].vld <= 1'b0;
    end else begin
      stage[0].vld <= start;
    end
    stage[0].rnd  <= 4'd1;
    stage[0].blk  <= {din.block_hi, din.block_lo};
    stage[0].st   <= {din.block_hi, din.block_lo} ^ {din.key_hi, din.key_lo};
    stage[0].rk   <= {din.key_hi, din.key_lo};
    stage[0].rcon <= 8'h01;
  end

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    aesmmo_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (stage[g]),
      .dout (stage[g+1])
    );
  end

  assign done = stage[NumRounds].vld;
  assign dout = out_item_t'(stage[NumRounds].st ^ stage[NumRounds].blk);

  `ASSERT_ALWAYS(a_never_busy, clk, rst, !busy, "busy raised")
  `ASSERT_NEXT(a_stage_one, clk, rst, start, stage[0].vld, "item lost at entry")
  `ASSERT_NEXT(a_chain, clk, rst, stage[NumRounds-1].vld, done, "item lost in chain")

endmodule

[test/tb_top.sv]
// Testbench for the AES-128 Matyas-Meyer-Oseas compression core
`timescale 1ns / 100ps
module tb_top;
  import aesmmo_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  din = '0;
  logic      done;
  out_item_t dout;

  in_item_t  pending_q[$];
  out_item_t digest_q[$];
  int        gap_left = 0;
  bit        gaps_on = 1'b1;
  bit        stim_done = 1'b0;
  int        fail_cnt = 0;
  int        cycle_cnt = 0;

  aes128_mmo_compress_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .din(din), .done(done), .dout(dout)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] gmul2(logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc ^= a;
      a = gmul2(a);
    end
    return acc;
  endfunction

  // S-box computed from the field inverse and affine map
  function automatic logic [7:0] sub_byte(logic [7:0] x);
    logic [7:0] p, inv;
    p = x;
    inv = 8'h01;
    for (int k = 1; k < 8; k++) begin
      p = gmul(p, p);
      inv = gmul(inv, p);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic out_item_t mmo_digest(in_item_t it);
    logic [7:0] blk[16], rk[176], s[16], t[16], w[4], f, rcon;
    logic [7:0] a0, a1, a2, a3;
    out_item_t  r;
    for (int i = 0; i < 8; i++) begin
      blk[i] = it.block_lo[8*i +: 8];
      blk[8+i] = it.block_hi[8*i +: 8];
      rk[i] = it.key_lo[8*i +: 8];
      rk[8+i] = it.key_hi[8*i +: 8];
    end
    rcon = 8'h01;
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
      if (i % 4 == 0) begin
        f = w[0];
        w[0] = sub_byte(w[1]) ^ rcon;
        w[1] = sub_byte(w[2]);
        w[2] = sub_byte(w[3]);
        w[3] = sub_byte(f);
        rcon = gmul2(rcon);
      end
      for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = blk[i] ^ rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int rw = 0; rw < 4; rw++) t[rw+4*c] = sub_byte(s[rw+4*((c+rw)%4)]);
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          t[4*c]   = gmul2(a0) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
          t[4*c+1] = a0 ^ gmul2(a1) ^ gmul(a2, 8'h03) ^ a3;
          t[4*c+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul(a3, 8'h03);
          t[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul2(a3);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 8; i++) begin
      r.out_lo[8*i +: 8] = s[i] ^ blk[i];
      r.out_hi[8*i +: 8] = s[8+i] ^ blk[8+i];
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) digest_q.push_back(mmo_digest(din));
      if (start && busy) begin
        // hold
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 14);
        start <= 1'b0;
      end else if (pending_q.size() > 0) begin
        din <= pending_q.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, dout);
        fail_cnt++;
      end else begin
        out_item_t want;
        want = digest_q.pop_front();
        if (dout.out_lo !== want.out_lo) begin
          $display("%0t: out_lo expected %h actual %h", $time, want.out_lo, dout.out_lo);
          fail_cnt++;
        end
        if (dout.out_hi !== want.out_hi) begin
          $display("%0t: out_hi expected %h actual %h", $time, want.out_hi, dout.out_hi);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 200000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    in_item_t it;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // FIPS-197 appendix vectors and field extremes
    it.block_lo = 64'h8877665544332211 ^ 64'h8877665544332211;
    it = '0;
    pending_q.push_back(it);
    pending_q.push_back('1);
    it = '0; it.block_lo = '1; it.block_hi = '1; pending_q.push_back(it);
    it = '0; it.key_lo = '1; it.key_hi = '1; pending_q.push_back(it);
    it.block_lo = 64'h7766554433221100; it.block_hi = 64'hffeeddccbbaa9988;
    it.key_lo = 64'h0706050403020100; it.key_hi = 64'h0f0e0d0c0b0a0908;
    pending_q.push_back(it);
    it.block_lo = 64'h313198a2e0370734; it.block_hi = 64'h0707a8d5a8f66f62;
    it.key_lo = 64'hd2a6abf7158809cf; it.key_hi = 64'h3c4fcf098815f7ab;
    it.block_lo = 64'h8d305a88a8f64332; it.block_hi = 64'h340737e0a2983131;
    it.key_lo = 64'ha6d2ae2816157e2b; it.key_hi = 64'h3c4fcf098815f7ab;
    pending_q.push_back(it);
    for (int b = 0; b < 64; b += 7) begin
      it = '0;
      it.block_lo[b] = 1'b1; it.block_hi[63-b] = 1'b1;
      it.key_lo[63-b] = 1'b1; it.key_hi[b] = 1'b1;
      pending_q.push_back(it);
    end
    for (int n = 0; n < 1700; n++) begin
      it.block_lo = rand64(); it.block_hi = rand64();
      it.key_lo = rand64(); it.key_hi = rand64();
      pending_q.push_back(it);
    end
    wait (pending_q.size() < 200);
    gaps_on = 1'b0;
    wait (pending_q.size() == 0 && !start);
    wait (digest_q.size() == 0);
    repeat (30) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hdl
hdl/aesmmo_pkg.sv
hdl/aesmmo_cell.sv
hdl/aes128_mmo_compress_core.sv
test/tb_top.sv
